### hw/rtl/bounded_doubly_linked_list_core_macros.svh
// Assertion macros used by the list core RTL.
`ifndef BOUNDED_DOUBLY_LINKED_LIST_CORE_MACROS_SVH
`define BOUNDED_DOUBLY_LINKED_LIST_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that the consequent holds in the same cycle as the antecedent.
`define BDLL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define BDLL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BDLL_ASSERT_NOW(label, ante, cons, msg)
`define BDLL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### hw/rtl/bdll_pkg.sv
// Shared constants, codes and control types of the bounded list core.
package bdll_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int KIND_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_FRONT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BACK   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

	// Datapath operations issued by the controller
	typedef logic [2:0] op_t;
	localparam op_t OP_NONE    = 3'd0;
	localparam op_t OP_LOAD    = 3'd1;
	localparam op_t OP_DECODE  = 3'd2;
	localparam op_t OP_INSERT  = 3'd3;
	localparam op_t OP_WALK    = 3'd4;
	localparam op_t OP_TAKE    = 3'd5;
	localparam op_t OP_UNLINK  = 3'd6;
	localparam op_t OP_PUBLISH = 3'd7;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic go_insert;
		logic go_walk;
		logic go_take;
		logic walk_last;
		logic out_free;
	} dp_stat_t;

endpackage

### hw/rtl/bdll_if.sv
// Request and result channel interfaces of the bounded list core.
interface bdll_req_if;
	logic                               valid;
	logic                               ready;
	logic [bdll_pkg::KIND_W-1:0]        kind;
	logic signed [bdll_pkg::VALUE_W-1:0] value;
	logic [bdll_pkg::POS_W-1:0]         position;

	modport source (output valid, kind, value, position, input ready);
	modport sink (input valid, kind, value, position, output ready);
endinterface

interface bdll_rsp_if #(
	parameter int CNT_W = $clog2(bdll_pkg::CAPACITY_DEF + 1)
);
	logic                                valid;
	logic                                ready;
	logic [bdll_pkg::STATUS_W-1:0]       status;
	logic signed [bdll_pkg::VALUE_W-1:0] removed_value;
	logic [CNT_W-1:0]                    element_count;

	modport source (output valid, status, removed_value, element_count, input ready);
	modport sink (input valid, status, removed_value, element_count, output ready);
endinterface

### hw/rtl/bounded_doubly_linked_list_core.sv
// Bounded doubly linked list core: holds up to CAPACITY signed 32-bit values.
// Requests arrive on req (valid/ready): kind 0 inserts value at the front,
// kind 1 at the back, kind 2 removes the element at 1-based position from the
// head (0 means the head); kind 3 changes nothing. Every request gives exactly
// one result on rsp: status (ok, empty, bad position, full), the removed value
// (zero unless a delete succeeded) and the element count after the request.
// One request is in work at a time. An insert passes the decode and insert
// steps, a rejected or ignored request only the decode step, and a delete
// the decode step, a walk past the head along the forward links, one link
// per cycle through the registered read of the link store, then the take and
// unlink steps. Each request ends in a done step that publishes its result.
// A result waits in an output register; the next request is taken while it
// waits, and its own result is held back until rsp takes the earlier one.
// Reset empties the list and refills the free list at once, with no clearing
// pass: slots not yet handed out are tracked by a fill count.
`include "bounded_doubly_linked_list_core_macros.svh"

module bounded_doubly_linked_list_core #(
	parameter int CAPACITY = bdll_pkg::CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	bdll_req_if.sink   req,
	bdll_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	bdll_pkg::dp_cmd_t  cmd;
	bdll_pkg::dp_stat_t stat;
	logic               in_ready;
	logic [CW-1:0]      out_count;

	bdll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bdll_datapath #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_kind     (req.kind),
		.req_value    (req.value),
		.req_position (req.position),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.out_status   (rsp.status),
		.out_removed  (rsp.removed_value),
		.out_count    (out_count)
	);

	assign req.ready         = in_ready;
	assign rsp.element_count = out_count;

	// Not ready in the cycle after a request is taken
	`BDLL_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "request taken while busy")
	// A full store reports the full count
	`BDLL_ASSERT_NOW(a_full_count, rsp.valid && (rsp.status == bdll_pkg::ST_FULL), out_count == CW'(CAPACITY), "full status with short count")
	// An empty list removes nothing and holds nothing
	`BDLL_ASSERT_NOW(a_empty_result, rsp.valid && (rsp.status == bdll_pkg::ST_EMPTY), (out_count == '0) && (rsp.removed_value == '0), "empty status with data")

endmodule

### hw/rtl/bdll_ctrl.sv
// Controller state machine sequencing one request through the list datapath.
module bdll_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bdll_pkg::dp_stat_t stat,
	output bdll_pkg::dp_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_INSERT = 3'd2;
	localparam logic [2:0] S_WALK   = 3'd3;
	localparam logic [2:0] S_TAKE   = 3'd4;
	localparam logic [2:0] S_UNLINK = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Pick the next state and the operation for this cycle
	always_comb begin
		state_d  = state_q;
		cmd.op   = bdll_pkg::OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = bdll_pkg::OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.op = bdll_pkg::OP_DECODE;
				if (stat.go_insert) begin
					state_d = S_INSERT;
				end else if (stat.go_walk) begin
					state_d = S_WALK;
				end else if (stat.go_take) begin
					state_d = S_TAKE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_INSERT: begin
				cmd.op  = bdll_pkg::OP_INSERT;
				state_d = S_DONE;
			end
			S_WALK: begin
				cmd.op = bdll_pkg::OP_WALK;
				if (stat.walk_last) begin
					state_d = S_TAKE;
				end
			end
			S_TAKE: begin
				cmd.op  = bdll_pkg::OP_TAKE;
				state_d = S_UNLINK;
			end
			S_UNLINK: begin
				cmd.op  = bdll_pkg::OP_UNLINK;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.op  = bdll_pkg::OP_PUBLISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hw/rtl/bdll_datapath.sv
// Datapath of the list core: slot stores, list pointers and result register.
module bdll_datapath #(
	parameter int CAPACITY = bdll_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bdll_pkg::dp_cmd_t                   cmd,
	output bdll_pkg::dp_stat_t                  stat,
	input  logic [bdll_pkg::KIND_W-1:0]         req_kind,
	input  logic signed [bdll_pkg::VALUE_W-1:0] req_value,
	input  logic [bdll_pkg::POS_W-1:0]          req_position,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bdll_pkg::STATUS_W-1:0]       out_status,
	output logic signed [bdll_pkg::VALUE_W-1:0] out_removed,
	output logic [CW-1:0]                       out_count
);

	localparam int PW    = bdll_pkg::POS_W;
	localparam int CMP_W = (CW > PW) ? CW : PW;

	// Slot stores
	logic signed [bdll_pkg::VALUE_W-1:0] val_mem_q [CAPACITY];
	logic [AW-1:0] fwd_mem_q  [CAPACITY];
	logic [AW-1:0] bwd_mem_q  [CAPACITY];
	logic [AW-1:0] free_mem_q [CAPACITY];

	logic signed [bdll_pkg::VALUE_W-1:0] val_rd_q;
	logic [AW-1:0] fwd_rd_q;
	logic [AW-1:0] bwd_rd_q;
	logic [AW-1:0] free_rd_q;

	// List pointers and request registers
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [AW-1:0] free_head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] fresh_q;
	logic [AW-1:0] cursor_q;
	logic [PW-1:0] remain_q;
	logic [bdll_pkg::KIND_W-1:0] kind_q;
	logic signed [bdll_pkg::VALUE_W-1:0] value_q;
	logic [PW-1:0] pos_q;
	logic [bdll_pkg::STATUS_W-1:0] status_q;
	logic signed [bdll_pkg::VALUE_W-1:0] removed_q;

	logic                                out_valid_q;
	logic [bdll_pkg::STATUS_W-1:0]       out_status_q;
	logic signed [bdll_pkg::VALUE_W-1:0] out_removed_q;
	logic [CW-1:0]                       out_count_q;

	// Request decode
	logic is_ins;
	logic is_front;
	logic is_del;
	logic full;
	logic empty;
	logic bad_pos;
	logic del_ok;
	logic del_first;
	logic del_last;
	logic del_single;
	logic is_fresh;
	logic [AW-1:0] alloc_slot;
	logic [AW-1:0] next_free;

	// Store ports
	logic                                val_we;
	logic                                fwd_we;
	logic                                bwd_we;
	logic                                free_we;
	logic [AW-1:0]                       fwd_wa;
	logic [AW-1:0]                       fwd_wd;
	logic [AW-1:0]                       bwd_wa;
	logic [AW-1:0]                       bwd_wd;
	logic [AW-1:0]                       fwd_ra;

	assign is_front   = (kind_q == bdll_pkg::KIND_FRONT);
	assign is_ins     = is_front || (kind_q == bdll_pkg::KIND_BACK);
	assign is_del     = (kind_q == bdll_pkg::KIND_DELETE);
	assign full       = (count_q == CW'(CAPACITY));
	assign empty      = (count_q == '0);
	assign bad_pos    = (CMP_W'(pos_q) > CMP_W'(count_q));
	assign del_ok     = is_del && !empty && !bad_pos;
	assign del_first  = (pos_q == PW'(1));
	assign del_last   = (CMP_W'(pos_q) == CMP_W'(count_q));
	assign del_single = (count_q == CW'(1));

	// Slots never handed out follow the free head in order; freed ones are stacked
	assign alloc_slot = free_head_q;
	assign is_fresh   = (CW'(free_head_q) == fresh_q);
	always_comb begin
		if (!is_fresh) begin
			next_free = free_rd_q;
		end else if (free_head_q == AW'(CAPACITY - 1)) begin
			next_free = '0;
		end else begin
			next_free = free_head_q + AW'(1);
		end
	end

	assign stat.go_insert = is_ins && !full;
	assign stat.go_walk   = del_ok && !del_first;
	assign stat.go_take   = del_ok && del_first;
	assign stat.walk_last = (remain_q == PW'(1));
	assign stat.out_free  = !out_valid_q || out_ready;

	// Steer store reads and writes for the current operation
	always_comb begin
		val_we  = 1'b0;
		fwd_we  = 1'b0;
		bwd_we  = 1'b0;
		free_we = 1'b0;
		fwd_wa  = alloc_slot;
		fwd_wd  = head_q;
		bwd_wa  = head_q;
		bwd_wd  = alloc_slot;
		fwd_ra  = cursor_q;
		unique case (cmd.op)
			bdll_pkg::OP_DECODE: begin
				fwd_ra = head_q;
			end
			bdll_pkg::OP_WALK: begin
				fwd_ra = fwd_rd_q;
			end
			bdll_pkg::OP_INSERT: begin
				val_we = 1'b1;
				if (!empty) begin
					fwd_we = 1'b1;
					bwd_we = 1'b1;
					if (!is_front) begin
						fwd_wa = tail_q;
						fwd_wd = alloc_slot;
						bwd_wa = alloc_slot;
						bwd_wd = tail_q;
					end
				end
			end
			bdll_pkg::OP_UNLINK: begin
				free_we = 1'b1;
				fwd_wa  = bwd_rd_q;
				fwd_wd  = fwd_rd_q;
				bwd_wa  = fwd_rd_q;
				bwd_wd  = bwd_rd_q;
				if (!del_single && !del_first && !del_last) begin
					fwd_we = 1'b1;
					bwd_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Write and read the slot stores
	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem_q[alloc_slot] <= value_q;
		end
		if (fwd_we) begin
			fwd_mem_q[fwd_wa] <= fwd_wd;
		end
		if (bwd_we) begin
			bwd_mem_q[bwd_wa] <= bwd_wd;
		end
		if (free_we) begin
			free_mem_q[cursor_q] <= free_head_q;
		end
		val_rd_q  <= val_mem_q[cursor_q];
		fwd_rd_q  <= fwd_mem_q[fwd_ra];
		bwd_rd_q  <= bwd_mem_q[cursor_q];
		free_rd_q <= free_mem_q[free_head_q];
	end

	// Update list pointers, counts and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			free_head_q <= '0;
			count_q     <= '0;
			fresh_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				bdll_pkg::OP_INSERT: begin
					if (empty) begin
						head_q <= alloc_slot;
						tail_q <= alloc_slot;
					end else if (is_front) begin
						head_q <= alloc_slot;
					end else begin
						tail_q <= alloc_slot;
					end
					free_head_q <= next_free;
					count_q     <= count_q + CW'(1);
					if (is_fresh) begin
						fresh_q <= fresh_q + CW'(1);
					end
				end
				bdll_pkg::OP_UNLINK: begin
					if (del_single) begin
						head_q <= '0;
						tail_q <= '0;
					end else if (del_first) begin
						head_q <= fwd_rd_q;
					end else if (del_last) begin
						tail_q <= bwd_rd_q;
					end
					free_head_q <= cursor_q;
					count_q     <= count_q - CW'(1);
				end
				default: begin
				end
			endcase
			if (cmd.op == bdll_pkg::OP_PUBLISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the request, walk state and result fields
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			bdll_pkg::OP_LOAD: begin
				kind_q  <= req_kind;
				value_q <= req_value;
				pos_q   <= (req_position == '0) ? PW'(1) : req_position;
			end
			bdll_pkg::OP_DECODE: begin
				removed_q <= '0;
				cursor_q  <= head_q;
				remain_q  <= pos_q - PW'(1);
				if (is_ins && full) begin
					status_q <= bdll_pkg::ST_FULL;
				end else if (is_del && empty) begin
					status_q <= bdll_pkg::ST_EMPTY;
				end else if (is_del && bad_pos) begin
					status_q <= bdll_pkg::ST_BADPOS;
				end else begin
					status_q <= bdll_pkg::ST_OK;
				end
			end
			bdll_pkg::OP_WALK: begin
				cursor_q <= fwd_rd_q;
				remain_q <= remain_q - PW'(1);
			end
			bdll_pkg::OP_UNLINK: begin
				removed_q <= val_rd_q;
			end
			bdll_pkg::OP_PUBLISH: begin
				out_status_q  <= status_q;
				out_removed_q <= removed_q;
				out_count_q   <= count_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_removed = out_removed_q;
	assign out_count   = out_count_q;

endmodule
